// File: hdl/led_matrix_scan_driver_assert.svh
// ----------------------------------------------------------------------------
// LED matrix scan driver assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_SCAN_DRIVER_ASSERT_SVH
`define LED_MATRIX_SCAN_DRIVER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define LMSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LMSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LMSD_ASSERT_NOW(label, ante, cons, msg)
`define LMSD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: hdl/lmsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix scan driver package
// Geometry constants, codes and shared types.
// ----------------------------------------------------------------------------
package lmsd_pkg;

    localparam int MAX_PANELS_ACROSS = 4;
    localparam int MAX_PANELS_DOWN   = 4;
    localparam int PANEL_COLUMNS     = 32;
    localparam int PANEL_ROWS        = 16;
    localparam int HALF_ROWS         = PANEL_ROWS / 2;

    localparam int STORE_W     = MAX_PANELS_ACROSS * PANEL_COLUMNS;
    localparam int STORE_H     = MAX_PANELS_DOWN * PANEL_ROWS;
    localparam int STORE_DEPTH = STORE_W * STORE_H;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PIXEL_W     = 3;

    localparam int X_W     = 7;
    localparam int Y_W     = 6;
    localparam int KIND_W  = 2;
    localparam int CNT_W   = 3;
    localparam int TIME_W  = 16;
    localparam int PCOL_W  = (MAX_PANELS_ACROSS > 1) ? $clog2(MAX_PANELS_ACROSS) : 1;
    localparam int PROW_W  = (MAX_PANELS_DOWN > 1) ? $clog2(MAX_PANELS_DOWN) : 1;
    localparam int COL_W   = $clog2(PANEL_COLUMNS);
    localparam int ROW_W   = $clog2(HALF_ROWS);

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [TIME_W-1:0] ON_TIME_RESET = 16'd300;

    localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [1:0] REG_PANELS_WIDE = 2'd0;
    localparam logic [1:0] REG_PANELS_HIGH = 2'd1;
    localparam logic [1:0] REG_ON_TIME     = 2'd2;

    typedef enum logic [2:0] {
        PH_BLANK_START,
        PH_SHIFT_HIGH,
        PH_SHIFT_LOW,
        PH_LATCH_HIGH,
        PH_LATCH_LOW,
        PH_ENABLE,
        PH_BLANK_END
    } phase_t;

    typedef struct packed {
        logic [PCOL_W-1:0] wide_last;
        logic [PROW_W-1:0] high_last;
        logic [TIME_W-1:0] on_time;
        logic [X_W:0]      width_px;
        logic [Y_W:0]      height_px;
    } cfg_t;

    typedef struct packed {
        logic             shift_clock;
        logic             latch;
        logic             output_enable;
        logic             data_on;
        logic [ROW_W-1:0] row_address;
    } pins_t;

endpackage

// File: hdl/lmsd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix scan driver input channel
// Valid/ready channel carrying draw, tick and clear items.
// ----------------------------------------------------------------------------
interface lmsd_in_if;
    logic                       valid;
    logic                       ready;
    logic [lmsd_pkg::KIND_W-1:0] kind;
    logic [lmsd_pkg::X_W-1:0]   pos_x;
    logic [lmsd_pkg::Y_W-1:0]   pos_y;
    logic                       red;
    logic                       green;
    logic                       blue;

    modport source (output valid, kind, pos_x, pos_y, red, green, blue, input ready);
    modport sink   (input valid, kind, pos_x, pos_y, red, green, blue, output ready);
endinterface

// File: hdl/lmsd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix scan driver output channel
// Valid/ready channel carrying one panel pin snapshot per transaction.
// ----------------------------------------------------------------------------
interface lmsd_out_if;
    logic                        valid;
    logic                        ready;
    logic                        red_top;
    logic                        green_top;
    logic                        blue_top;
    logic                        red_bottom;
    logic                        green_bottom;
    logic                        blue_bottom;
    logic                        shift_clock;
    logic                        latch;
    logic                        output_enable;
    logic [lmsd_pkg::ROW_W-1:0]  row_address;

    modport source (output valid, red_top, green_top, blue_top, red_bottom, green_bottom,
                    blue_bottom, shift_clock, latch, output_enable, row_address,
                    input ready);
    modport sink   (input valid, red_top, green_top, blue_top, red_bottom, green_bottom,
                    blue_bottom, shift_clock, latch, output_enable, row_address,
                    output ready);
endinterface

// File: hdl/lmsd_pixel_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix scan driver pixel RAM
// One write port, two registered read ports sharing one read enable.
// ----------------------------------------------------------------------------
module lmsd_pixel_ram #(
    parameter int WIDTH  = 3,
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WIDTH-1:0]  rd_data_a,
    output logic [WIDTH-1:0]  rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold the read data until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// File: hdl/lmsd_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix scan driver configuration registers
// APB register file with clamped geometry and on time.
// ----------------------------------------------------------------------------
module lmsd_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lmsd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lmsd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lmsd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output lmsd_pkg::cfg_t                      cfg
);

    logic [lmsd_pkg::CNT_W-1:0]  wide_reg;
    logic [lmsd_pkg::CNT_W-1:0]  wide_next;
    logic [lmsd_pkg::CNT_W-1:0]  high_reg;
    logic [lmsd_pkg::CNT_W-1:0]  high_next;
    logic [lmsd_pkg::TIME_W-1:0] on_time_reg;
    logic [lmsd_pkg::TIME_W-1:0] on_time_next;
    logic                        wr_fire;
    logic [1:0]                  reg_index;

    assign pready    = 1'b1;
    assign wr_fire   = psel && penable && pwrite;
    assign reg_index = paddr[3:2];

    always_comb
    begin
        wide_next    = wide_reg;
        high_next    = high_reg;
        on_time_next = on_time_reg;
        if (wr_fire)
        begin
            case (reg_index)
                lmsd_pkg::REG_PANELS_WIDE: wide_next    = pwdata[lmsd_pkg::CNT_W-1:0];
                lmsd_pkg::REG_PANELS_HIGH: high_next    = pwdata[lmsd_pkg::CNT_W-1:0];
                lmsd_pkg::REG_ON_TIME:     on_time_next = pwdata[lmsd_pkg::TIME_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg    <= lmsd_pkg::CNT_W'(1);
            high_reg    <= lmsd_pkg::CNT_W'(1);
            on_time_reg <= lmsd_pkg::ON_TIME_RESET;
        end
        else
        begin
            wide_reg    <= wide_next;
            high_reg    <= high_next;
            on_time_reg <= on_time_next;
        end
    end

    always_comb
    begin
        case (reg_index)
            lmsd_pkg::REG_PANELS_WIDE: prdata = lmsd_pkg::APB_DATA_W'(wide_reg);
            lmsd_pkg::REG_PANELS_HIGH: prdata = lmsd_pkg::APB_DATA_W'(high_reg);
            lmsd_pkg::REG_ON_TIME:     prdata = lmsd_pkg::APB_DATA_W'(on_time_reg);
            default:                   prdata = '0;
        endcase
    end

    // Zero acts as one, anything above the maximum as the maximum.
    always_comb
    begin
        if (wide_reg == '0)
            cfg.wide_last = '0;
        else if (32'(wide_reg) > lmsd_pkg::MAX_PANELS_ACROSS)
            cfg.wide_last = lmsd_pkg::PCOL_W'(lmsd_pkg::MAX_PANELS_ACROSS - 1);
        else
            cfg.wide_last = lmsd_pkg::PCOL_W'(32'(wide_reg) - 1);

        if (high_reg == '0)
            cfg.high_last = '0;
        else if (32'(high_reg) > lmsd_pkg::MAX_PANELS_DOWN)
            cfg.high_last = lmsd_pkg::PROW_W'(lmsd_pkg::MAX_PANELS_DOWN - 1);
        else
            cfg.high_last = lmsd_pkg::PROW_W'(32'(high_reg) - 1);

        cfg.on_time   = (on_time_reg == '0) ? lmsd_pkg::TIME_W'(1) : on_time_reg;
        cfg.width_px  = (lmsd_pkg::X_W + 1)'((32'(cfg.wide_last) + 1)
                        * lmsd_pkg::PANEL_COLUMNS);
        cfg.height_px = (lmsd_pkg::Y_W + 1)'((32'(cfg.high_last) + 1)
                        * lmsd_pkg::PANEL_ROWS);
    end

endmodule

// File: hdl/lmsd_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix scan driver sequencer
// Phase machine and shift counters, advanced once per scan tick.
// ----------------------------------------------------------------------------
module lmsd_scan (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tick,
    input  lmsd_pkg::cfg_t                cfg,
    output lmsd_pkg::pins_t               pins,
    output logic [lmsd_pkg::ADDR_W-1:0]   top_addr,
    output logic [lmsd_pkg::ADDR_W-1:0]   bottom_addr
);

    localparam logic [lmsd_pkg::COL_W-1:0] COL_LAST =
        lmsd_pkg::COL_W'(lmsd_pkg::PANEL_COLUMNS - 1);

    lmsd_pkg::phase_t              phase_reg;
    lmsd_pkg::phase_t              phase_next;
    logic [lmsd_pkg::ROW_W-1:0]    row_reg;
    logic [lmsd_pkg::ROW_W-1:0]    row_next;
    logic [lmsd_pkg::PCOL_W-1:0]   pcol_reg;
    logic [lmsd_pkg::PCOL_W-1:0]   pcol_next;
    logic [lmsd_pkg::PROW_W-1:0]   prow_reg;
    logic [lmsd_pkg::PROW_W-1:0]   prow_next;
    logic [lmsd_pkg::COL_W-1:0]    col_reg;
    logic [lmsd_pkg::COL_W-1:0]    col_next;
    logic [lmsd_pkg::TIME_W-1:0]   timer_reg;
    logic [lmsd_pkg::TIME_W-1:0]   timer_next;
    logic [lmsd_pkg::TIME_W-1:0]   timer_dec;
    logic [lmsd_pkg::X_W-1:0]      pix_x;
    logic [lmsd_pkg::Y_W-1:0]      pix_y_top;
    logic [lmsd_pkg::Y_W-1:0]      pix_y_bottom;

    assign timer_dec = (timer_reg != '0) ? timer_reg - 1'b1 : '0;

    // Next state.
    always_comb
    begin
        phase_next = phase_reg;
        row_next   = row_reg;
        pcol_next  = pcol_reg;
        prow_next  = prow_reg;
        col_next   = col_reg;
        timer_next = timer_reg;
        case (phase_reg)
            lmsd_pkg::PH_BLANK_START:
            begin
                pcol_next  = cfg.wide_last;
                prow_next  = cfg.high_last;
                col_next   = '0;
                phase_next = lmsd_pkg::PH_SHIFT_HIGH;
            end
            lmsd_pkg::PH_SHIFT_HIGH:
            begin
                phase_next = lmsd_pkg::PH_SHIFT_LOW;
            end
            lmsd_pkg::PH_SHIFT_LOW:
            begin
                phase_next = lmsd_pkg::PH_SHIFT_HIGH;
                if (col_reg != COL_LAST)
                begin
                    col_next = col_reg + 1'b1;
                end
                else
                begin
                    col_next = '0;
                    if (prow_reg != '0)
                    begin
                        prow_next = prow_reg - 1'b1;
                    end
                    else if (pcol_reg != '0)
                    begin
                        prow_next = cfg.high_last;
                        pcol_next = pcol_reg - 1'b1;
                    end
                    else
                    begin
                        prow_next  = '0;
                        phase_next = lmsd_pkg::PH_LATCH_HIGH;
                    end
                end
            end
            lmsd_pkg::PH_LATCH_HIGH:
            begin
                phase_next = lmsd_pkg::PH_LATCH_LOW;
            end
            lmsd_pkg::PH_LATCH_LOW:
            begin
                timer_next = cfg.on_time;
                phase_next = lmsd_pkg::PH_ENABLE;
            end
            lmsd_pkg::PH_ENABLE:
            begin
                timer_next = timer_dec;
                if (timer_dec == '0)
                    phase_next = lmsd_pkg::PH_BLANK_END;
            end
            default:
            begin
                row_next   = row_reg + 1'b1;
                phase_next = lmsd_pkg::PH_BLANK_START;
            end
        endcase
    end

    // Pin levels for the current phase.
    always_comb
    begin
        pins.shift_clock   = (phase_reg == lmsd_pkg::PH_SHIFT_HIGH);
        pins.data_on       = (phase_reg == lmsd_pkg::PH_SHIFT_HIGH) ||
                             (phase_reg == lmsd_pkg::PH_SHIFT_LOW);
        pins.latch         = (phase_reg == lmsd_pkg::PH_LATCH_HIGH);
        pins.output_enable = (phase_reg != lmsd_pkg::PH_ENABLE);
        pins.row_address   = row_reg;
    end

    always_comb
    begin
        pix_x        = lmsd_pkg::X_W'(32'(pcol_reg) * lmsd_pkg::PANEL_COLUMNS
                       + 32'(col_reg));
        pix_y_top    = lmsd_pkg::Y_W'(32'(prow_reg) * lmsd_pkg::PANEL_ROWS
                       + 32'(row_reg));
        pix_y_bottom = lmsd_pkg::Y_W'(32'(pix_y_top) + lmsd_pkg::HALF_ROWS);
        top_addr     = lmsd_pkg::ADDR_W'(32'(pix_y_top) * lmsd_pkg::STORE_W
                       + 32'(pix_x));
        bottom_addr  = lmsd_pkg::ADDR_W'(32'(pix_y_bottom) * lmsd_pkg::STORE_W
                       + 32'(pix_x));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= lmsd_pkg::PH_BLANK_START;
            row_reg   <= '0;
            pcol_reg  <= '0;
            prow_reg  <= '0;
            col_reg   <= '0;
            timer_reg <= '0;
        end
        else if (tick)
        begin
            phase_reg <= phase_next;
            row_reg   <= row_next;
            pcol_reg  <= pcol_next;
            prow_reg  <= prow_next;
            col_reg   <= col_next;
            timer_reg <= timer_next;
        end
    end

endmodule

// File: hdl/led_matrix_scan_driver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix scan driver
// Framebuffer and scan sequencer for chained 32x16 RGB panels, 1/8 scan.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one transaction per item: kind 0 draws a pixel, kind 1 is a
//   scan tick, kind 2 clears the framebuffer, kind 3 is taken and dropped.
//   out_ch carries one pin snapshot for every scan tick, in tick order.
//   A tick's snapshot appears in the cycle after its transaction, registered
//   alongside the pixel RAM's read. Draw and tick items go at one per cycle
//   while in_ch is ready, and a tick may be taken in the same cycle as the
//   previous snapshot leaves.
//   A clear, and reset, start a clearing pass that writes zero to all 8192
//   pixel entries, one a cycle: in_ch is not ready until the pass ends.
//   APB writes are taken at any time; pready is tied high.
//   When the receiver stalls, the snapshot holds in the output register and
//   in_ch takes no item of any kind until the held snapshot is taken.
// ----------------------------------------------------------------------------
`include "led_matrix_scan_driver_assert.svh"

module led_matrix_scan_driver (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lmsd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lmsd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lmsd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    lmsd_in_if.sink                         in_ch,
    lmsd_out_if.source                      out_ch
);

    localparam logic [lmsd_pkg::ADDR_W-1:0] CLEAR_LAST =
        lmsd_pkg::ADDR_W'(lmsd_pkg::STORE_DEPTH - 1);

    lmsd_pkg::cfg_t                 cfg;
    lmsd_pkg::pins_t                scan_pins;
    lmsd_pkg::pins_t                pins_reg;
    logic [lmsd_pkg::ADDR_W-1:0]    top_addr;
    logic [lmsd_pkg::ADDR_W-1:0]    bottom_addr;
    logic [lmsd_pkg::PIXEL_W-1:0]   top_pixel;
    logic [lmsd_pkg::PIXEL_W-1:0]   bottom_pixel;

    logic                           in_fire;
    logic                           tick_fire;
    logic                           draw_fire;
    logic                           clear_fire;
    logic                           draw_inside;
    logic [lmsd_pkg::ADDR_W-1:0]    draw_addr;

    logic                           clearing_reg;
    logic                           clearing_next;
    logic [lmsd_pkg::ADDR_W-1:0]    clear_addr_reg;
    logic [lmsd_pkg::ADDR_W-1:0]    clear_addr_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;

    logic                           ram_wr_en;
    logic [lmsd_pkg::ADDR_W-1:0]    ram_wr_addr;
    logic [lmsd_pkg::PIXEL_W-1:0]   ram_wr_data;

    lmsd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Advance the sequencer only on an accepted tick.
    lmsd_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (tick_fire),
        .cfg         (cfg),
        .pins        (scan_pins),
        .top_addr    (top_addr),
        .bottom_addr (bottom_addr)
    );

    // Take a new transaction of any kind unless clearing, or while a snapshot
    // is still waiting and the receiver is not taking it.
    assign in_ch.ready = !clearing_reg && (!out_valid_reg || out_ch.ready);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign tick_fire   = in_fire && (in_ch.kind == lmsd_pkg::KIND_TICK);
    assign draw_fire   = in_fire && (in_ch.kind == lmsd_pkg::KIND_DRAW);
    assign clear_fire  = in_fire && (in_ch.kind == lmsd_pkg::KIND_CLEAR);

    // Drop draws outside the configured panel area.
    assign draw_inside = ({1'b0, in_ch.pos_x} < cfg.width_px) &&
                         ({1'b0, in_ch.pos_y} < cfg.height_px);
    assign draw_addr   = lmsd_pkg::ADDR_W'(32'(in_ch.pos_y) * lmsd_pkg::STORE_W
                         + 32'(in_ch.pos_x));

    // The clearing pass owns the write port; no item is taken meanwhile.
    always_comb
    begin
        if (clearing_reg)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clear_addr_reg;
            ram_wr_data = '0;
        end
        else
        begin
            ram_wr_en   = draw_fire && draw_inside;
            ram_wr_addr = draw_addr;
            ram_wr_data = {in_ch.blue, in_ch.green, in_ch.red};
        end
    end

    lmsd_pixel_ram #(
        .WIDTH (lmsd_pkg::PIXEL_W),
        .DEPTH (lmsd_pkg::STORE_DEPTH)
    ) u_ram (
        .clk       (clk),
        .wr_en     (ram_wr_en),
        .wr_addr   (ram_wr_addr),
        .wr_data   (ram_wr_data),
        .rd_en     (tick_fire),
        .rd_addr_a (top_addr),
        .rd_addr_b (bottom_addr),
        .rd_data_a (top_pixel),
        .rd_data_b (bottom_pixel)
    );

    always_comb
    begin
        clearing_next   = clearing_reg;
        clear_addr_next = clear_addr_reg;
        if (clear_fire)
        begin
            clearing_next   = 1'b1;
            clear_addr_next = '0;
        end
        else if (clearing_reg)
        begin
            clear_addr_next = clear_addr_reg + 1'b1;
            if (clear_addr_reg == CLEAR_LAST)
                clearing_next = 1'b0;
        end
    end

    // Hold the snapshot until the receiver takes it.
    always_comb
    begin
        if (tick_fire)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            clearing_reg   <= clearing_next;
            clear_addr_reg <= clear_addr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Capture the control pins alongside the RAM read of the same tick.
    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            pins_reg <= scan_pins;
        end
    end

    // Data lines show the pixels only while shifting.
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.red_top       = top_pixel[0] & pins_reg.data_on;
    assign out_ch.green_top     = top_pixel[1] & pins_reg.data_on;
    assign out_ch.blue_top      = top_pixel[2] & pins_reg.data_on;
    assign out_ch.red_bottom    = bottom_pixel[0] & pins_reg.data_on;
    assign out_ch.green_bottom  = bottom_pixel[1] & pins_reg.data_on;
    assign out_ch.blue_bottom   = bottom_pixel[2] & pins_reg.data_on;
    assign out_ch.shift_clock   = pins_reg.shift_clock;
    assign out_ch.latch         = pins_reg.latch;
    assign out_ch.output_enable = pins_reg.output_enable;
    assign out_ch.row_address   = pins_reg.row_address;

    `LMSD_ASSERT_NEXT(a_tick_gives_snapshot, tick_fire, out_valid_reg,
                      "tick lost its snapshot")
    `LMSD_ASSERT_NEXT(a_no_snapshot_while_clearing, clearing_reg && !out_valid_reg,
                      !out_valid_reg, "snapshot appeared during clearing pass")
    `LMSD_ASSERT_NOW(a_blank_while_shifting,
                     out_valid_reg && (out_ch.shift_clock || out_ch.latch),
                     out_ch.output_enable, "outputs enabled during shift or latch")
    `LMSD_ASSERT_NOW(a_row_moves_on_tick, !$stable(scan_pins.row_address),
                     $past(tick_fire), "scan row moved without a tick")

endmodule

// File: test/led_matrix_scan_driver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix scan driver testbench
// Drives draw, tick and clear items through the input channel under random
// gaps and output back-pressure. A cycle-free model of the framebuffer and
// scan sequencer predicts every pin snapshot, which is checked field by field
// against what leaves the output channel. Configuration is rewritten over
// APB between phases, including out-of-range panel counts and on times.
// ----------------------------------------------------------------------------
module led_matrix_scan_driver_test;

    // No transaction on either channel for this many cycles ends the run.
    // It must outlast a whole clearing pass.
    localparam int QUIET_LIMIT = 40000;
    localparam int LONG_HOLD   = 300;
    localparam int MAX_GAP     = 17;

    localparam logic [lmsd_pkg::KIND_W-1:0] KIND_IGNORED = 2'd3;

    typedef struct packed {
        logic [lmsd_pkg::KIND_W-1:0] kind;
        logic [lmsd_pkg::X_W-1:0]    pos_x;
        logic [lmsd_pkg::Y_W-1:0]    pos_y;
        logic                        red;
        logic                        green;
        logic                        blue;
    } scan_item_t;

    // Packed order matches pins_of(): top rgb, bottom rgb, clock, latch, blank, row.
    typedef struct packed {
        logic                       red_top;
        logic                       green_top;
        logic                       blue_top;
        logic                       red_bottom;
        logic                       green_bottom;
        logic                       blue_bottom;
        logic                       shift_clock;
        logic                       latch;
        logic                       output_enable;
        logic [lmsd_pkg::ROW_W-1:0] row_address;
    } pin_snap_t;

    typedef struct {
        scan_item_t item;
        bit         typed;
        pin_snap_t  want;
    } script_row_t;

    typedef struct {
        logic [lmsd_pkg::CNT_W-1:0]  wide;
        logic [lmsd_pkg::CNT_W-1:0]  high;
        logic [lmsd_pkg::TIME_W-1:0] on_time;
        int                          count;
        bit                          hold;
        bit                          drain;
    } setting_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [lmsd_pkg::APB_ADDR_W-1:0] paddr;
    logic [lmsd_pkg::APB_DATA_W-1:0] pwdata;
    logic [lmsd_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    lmsd_in_if  in_ch ();
    lmsd_out_if out_ch ();

    led_matrix_scan_driver u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Scan model: its own copy of the framebuffer, registers and sequencer
    // ------------------------------------------------------------------------
    logic [lmsd_pkg::PIXEL_W-1:0] frame_px [lmsd_pkg::STORE_DEPTH];
    logic [lmsd_pkg::CNT_W-1:0]   cfg_wide;
    logic [lmsd_pkg::CNT_W-1:0]   cfg_high;
    logic [lmsd_pkg::TIME_W-1:0]  cfg_on;
    logic [lmsd_pkg::ROW_W-1:0]   row_sel;
    lmsd_pkg::phase_t             seq_phase;
    int                           pcol_left;
    int                           prow_left;
    int                           col_idx;
    logic [lmsd_pkg::TIME_W-1:0]  dwell_left;

    pin_snap_t pins_due [$];    // snapshots still owed, oldest first
    int        fault_count = 0;
    int        quiet_cycles = 0;

    // Shared between the sender, the receiver and the input monitor
    bit        calm = 1'b0;          // both sides run without idling
    bit        hold_pending = 1'b0;  // receiver takes one long hold-off next
    bit        want_typed = 1'b0;    // the tick on offer carries a typed snapshot
    pin_snap_t want_pins = '0;

    // A count of zero behaves as one, anything above the maximum as the maximum
    function automatic int panels_across();
        if (cfg_wide == 0) return 1;
        if (cfg_wide > lmsd_pkg::MAX_PANELS_ACROSS) return lmsd_pkg::MAX_PANELS_ACROSS;
        return int'(cfg_wide);
    endfunction

    function automatic int panels_down();
        if (cfg_high == 0) return 1;
        if (cfg_high > lmsd_pkg::MAX_PANELS_DOWN) return lmsd_pkg::MAX_PANELS_DOWN;
        return int'(cfg_high);
    endfunction

    function automatic void wipe_frame();
        foreach (frame_px[i])
            frame_px[i] = '0;
    endfunction

    function automatic pin_snap_t pins_of(logic [2:0] top_rgb, logic [2:0] bot_rgb,
                                          logic sclk, logic lat, logic oe,
                                          logic [lmsd_pkg::ROW_W-1:0] row);
        return {top_rgb, bot_rgb, sclk, lat, oe, row};
    endfunction

    // Advance the sequencer by one tick and return the pins it drives
    function automatic pin_snap_t scan_step();
        pin_snap_t                    snap;
        logic [lmsd_pkg::PIXEL_W-1:0] top;
        logic [lmsd_pkg::PIXEL_W-1:0] bot;
        int                           x;
        int                           y;

        snap = '0;
        snap.output_enable = 1'b1;
        snap.row_address   = row_sel;
        case (seq_phase)
            lmsd_pkg::PH_BLANK_START:
            begin
                pcol_left = panels_across() - 1;
                prow_left = panels_down() - 1;
                col_idx   = 0;
                seq_phase = lmsd_pkg::PH_SHIFT_HIGH;
            end
            lmsd_pkg::PH_SHIFT_HIGH, lmsd_pkg::PH_SHIFT_LOW:
            begin
                x   = pcol_left * lmsd_pkg::PANEL_COLUMNS + col_idx;
                y   = prow_left * lmsd_pkg::PANEL_ROWS + int'(row_sel);
                top = frame_px[y * lmsd_pkg::STORE_W + x];
                bot = frame_px[(y + lmsd_pkg::HALF_ROWS) * lmsd_pkg::STORE_W + x];
                snap.red_top      = top[0];
                snap.green_top    = top[1];
                snap.blue_top     = top[2];
                snap.red_bottom   = bot[0];
                snap.green_bottom = bot[1];
                snap.blue_bottom  = bot[2];
                if (seq_phase == lmsd_pkg::PH_SHIFT_HIGH)
                begin
                    snap.shift_clock = 1'b1;
                    seq_phase = lmsd_pkg::PH_SHIFT_LOW;
                end
                else
                begin
                    // Columns first, ascending, then panel rows, then panel columns, both descending
                    seq_phase = lmsd_pkg::PH_SHIFT_HIGH;
                    if (col_idx < lmsd_pkg::PANEL_COLUMNS - 1)
                        col_idx++;
                    else
                    begin
                        col_idx = 0;
                        if (prow_left > 0)
                            prow_left--;
                        else
                        begin
                            prow_left = panels_down() - 1;
                            if (pcol_left > 0)
                                pcol_left--;
                            else
                            begin
                                prow_left = 0;
                                seq_phase = lmsd_pkg::PH_LATCH_HIGH;
                            end
                        end
                    end
                end
            end
            lmsd_pkg::PH_LATCH_HIGH:
            begin
                snap.latch = 1'b1;
                seq_phase = lmsd_pkg::PH_LATCH_LOW;
            end
            lmsd_pkg::PH_LATCH_LOW:
            begin
                // On time is sampled here; zero behaves as one
                dwell_left = (cfg_on == 0) ? lmsd_pkg::TIME_W'(1) : cfg_on;
                seq_phase = lmsd_pkg::PH_ENABLE;
            end
            lmsd_pkg::PH_ENABLE:
            begin
                snap.output_enable = 1'b0;
                if (dwell_left > 0)
                    dwell_left--;
                if (dwell_left == 0)
                    seq_phase = lmsd_pkg::PH_BLANK_END;
            end
            default:
            begin
                // Closing blank: move on to the next scan row
                row_sel   = row_sel + 1'b1;
                seq_phase = lmsd_pkg::PH_BLANK_START;
            end
        endcase
        return snap;
    endfunction

    function automatic void take_item(scan_item_t it);
        pin_snap_t snap;

        case (it.kind)
            lmsd_pkg::KIND_DRAW:
            begin
                if (it.pos_x < panels_across() * lmsd_pkg::PANEL_COLUMNS &&
                    it.pos_y < panels_down() * lmsd_pkg::PANEL_ROWS)
                    frame_px[it.pos_y * lmsd_pkg::STORE_W + it.pos_x] =
                        {it.blue, it.green, it.red};
            end
            lmsd_pkg::KIND_TICK:
            begin
                snap = scan_step();
                if (want_typed)
                    snap = want_pins;
                pins_due.push_back(snap);
            end
            lmsd_pkg::KIND_CLEAR:
                wipe_frame();
            default:
                ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Monitors: both sample at the rising edge, before the edge's updates land
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            take_item('{in_ch.kind, in_ch.pos_x, in_ch.pos_y,
                        in_ch.red, in_ch.green, in_ch.blue});
    end

    task automatic check_bit(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endtask

    task automatic check_row(input string name, input logic [lmsd_pkg::ROW_W-1:0] want,
                             input logic [lmsd_pkg::ROW_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endtask

    task automatic check_snapshot(input pin_snap_t want);
        check_bit("red_top",       want.red_top,       out_ch.red_top);
        check_bit("green_top",     want.green_top,     out_ch.green_top);
        check_bit("blue_top",      want.blue_top,      out_ch.blue_top);
        check_bit("red_bottom",    want.red_bottom,    out_ch.red_bottom);
        check_bit("green_bottom",  want.green_bottom,  out_ch.green_bottom);
        check_bit("blue_bottom",   want.blue_bottom,   out_ch.blue_bottom);
        check_bit("shift_clock",   want.shift_clock,   out_ch.shift_clock);
        check_bit("latch",         want.latch,         out_ch.latch);
        check_bit("output_enable", want.output_enable, out_ch.output_enable);
        check_row("row_address",   want.row_address,   out_ch.row_address);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pins_due.size() == 0)
            begin
                $error("snapshot transaction with no tick outstanding");
                fault_count++;
            end
            else
                check_snapshot(pins_due.pop_front());
        end
    end

    // Watchdog: give up once neither channel has moved for too long
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall before each transaction, plus one long hold-off
    // ------------------------------------------------------------------------
    initial
    begin
        int stall;

        out_ch.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (hold_pending)
            begin
                // Hold off long enough for the snapshot register to fill and
                // the input to back up behind it
                hold_pending = 1'b0;
                stall = LONG_HOLD;
            end
            else
                stall = calm ? 0 : int'($urandom_range(0, MAX_GAP));
            if (stall > 0)
            begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Sender and APB helpers
    // ------------------------------------------------------------------------
    // Offer one item after a random gap, none when calm; return at the edge that accepts it,
    // with valid still high so a back-to-back item keeps it raised
    task automatic offer(input scan_item_t it, input bit typed, input pin_snap_t want);
        int gap;

        gap = calm ? 0 : int'($urandom_range(0, MAX_GAP));
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.kind  = it.kind;
        in_ch.pos_x = it.pos_x;
        in_ch.pos_y = it.pos_y;
        in_ch.red   = it.red;
        in_ch.green = it.green;
        in_ch.blue  = it.blue;
        want_typed  = typed;
        want_pins   = want;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Drop valid, wait for every owed snapshot, then let the pipe drain
    task automatic settle();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pins_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write a register, then read it back
    task automatic reg_write_check(input logic [1:0] idx,
                                   input logic [lmsd_pkg::APB_DATA_W-1:0] value,
                                   input logic [lmsd_pkg::APB_DATA_W-1:0] mask);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            lmsd_pkg::REG_PANELS_WIDE: cfg_wide = value[lmsd_pkg::CNT_W-1:0];
            lmsd_pkg::REG_PANELS_HIGH: cfg_high = value[lmsd_pkg::CNT_W-1:0];
            lmsd_pkg::REG_ON_TIME:     cfg_on   = value[lmsd_pkg::TIME_W-1:0];
            default:                   ;
        endcase
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== (value & mask))
        begin
            $error("register %0d readback: expected %0h, got %0h", idx, value & mask, prdata);
            fault_count++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Random item; in_use says whether it can change the block's state
    function automatic scan_item_t random_item(output bit in_use);
        scan_item_t it;
        int         pick;

        it.pos_x = lmsd_pkg::X_W'($urandom_range(0, 127));
        it.pos_y = lmsd_pkg::Y_W'($urandom_range(0, 63));
        it.red   = 1'($urandom_range(0, 1));
        it.green = 1'($urandom_range(0, 1));
        it.blue  = 1'($urandom_range(0, 1));
        pick = int'($urandom_range(0, 199));
        if (pick == 0)
        begin
            it.kind = lmsd_pkg::KIND_CLEAR;    // rare: each one costs a full clearing pass
            in_use  = 1'b1;
        end
        else if (pick < 7)
        begin
            it.kind = KIND_IGNORED;
            in_use  = 1'b0;
        end
        else if (pick < 90)
        begin
            it.kind = lmsd_pkg::KIND_DRAW;
            // Keep most draws on the visible area so the shifted data varies
            if ($urandom_range(0, 9) < 8)
            begin
                it.pos_x = lmsd_pkg::X_W'($urandom_range(0,
                               panels_across() * lmsd_pkg::PANEL_COLUMNS - 1));
                it.pos_y = lmsd_pkg::Y_W'($urandom_range(0,
                               panels_down() * lmsd_pkg::PANEL_ROWS - 1));
            end
            in_use = it.pos_x < panels_across() * lmsd_pkg::PANEL_COLUMNS &&
                     it.pos_y < panels_down() * lmsd_pkg::PANEL_ROWS;
        end
        else
        begin
            it.kind = lmsd_pkg::KIND_TICK;
            in_use  = 1'b1;
        end
        return it;
    endfunction

    function automatic script_row_t entry(logic [lmsd_pkg::KIND_W-1:0] kind,
                                          logic [lmsd_pkg::X_W-1:0] x,
                                          logic [lmsd_pkg::Y_W-1:0] y,
                                          logic r, logic g, logic b,
                                          bit typed = 1'b0, pin_snap_t want = '0);
        script_row_t row;

        row.item  = '{kind, x, y, r, g, b};
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    // Register settings per random phase: zero and over-range panel counts,
    // zero and maximum on time, the largest array with few items
    setting_t plan [7] = '{
        '{3'd1, 3'd1, 16'd1,     350, 1'b1, 1'b0},
        '{3'd0, 3'd7, 16'd0,     180, 1'b0, 1'b0},
        '{3'd4, 3'd4, 16'd3,     130, 1'b0, 1'b0},
        '{3'd2, 3'd1, 16'd2,     220, 1'b0, 1'b1},
        '{3'd7, 3'd0, 16'd65535,  90, 1'b0, 1'b0},
        '{3'd1, 3'd2, 16'd5,     180, 1'b0, 1'b0},
        '{3'd3, 3'd3, 16'd1,     220, 1'b0, 1'b0}
    };

    script_row_t script [$];

    initial
    begin
        scan_item_t it;
        bit         in_use;
        int         done;
        bit         paused;

        // Drive every input to a known level before reset releases
        in_ch.valid = 1'b0;
        in_ch.kind  = lmsd_pkg::KIND_DRAW;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        in_ch.red   = 1'b0;
        in_ch.green = 1'b0;
        in_ch.blue  = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;

        // Model state after reset
        wipe_frame();
        cfg_wide   = 3'd1;
        cfg_high   = 3'd1;
        cfg_on     = lmsd_pkg::ON_TIME_RESET;
        row_sel    = '0;
        seq_phase  = lmsd_pkg::PH_BLANK_START;
        pcol_left  = 0;
        prow_left  = 0;
        col_idx    = 0;
        dwell_left = '0;

        // Directed part at reset settings: one 32x16 panel, on time 300.
        // The first tick is the opening blank; after the draws at (0,0) and (0,8) the
        // first shift pair shows them, bottom half eight rows down.
        script.push_back(entry(lmsd_pkg::KIND_TICK,   0,  0, 0, 0, 0,
                               1'b1, pins_of(3'b000, 3'b000, 1'b0, 1'b0, 1'b1, 3'd0)));
        script.push_back(entry(lmsd_pkg::KIND_DRAW,   0,  0, 1, 1, 1));
        script.push_back(entry(lmsd_pkg::KIND_DRAW,   0,  8, 1, 0, 1));
        script.push_back(entry(lmsd_pkg::KIND_DRAW,  31, 15, 1, 1, 1));
        script.push_back(entry(lmsd_pkg::KIND_DRAW, 127, 63, 1, 1, 1));   // off the panel
        script.push_back(entry(lmsd_pkg::KIND_DRAW,  32,  0, 0, 1, 0));   // one column too far
        script.push_back(entry(lmsd_pkg::KIND_DRAW,   0, 16, 0, 1, 0));   // one row too far
        script.push_back(entry(KIND_IGNORED,        127, 63, 1, 1, 1));
        script.push_back(entry(lmsd_pkg::KIND_TICK,   0,  0, 0, 0, 0,
                               1'b1, pins_of(3'b111, 3'b101, 1'b1, 1'b0, 1'b1, 3'd0)));
        script.push_back(entry(lmsd_pkg::KIND_TICK,   0,  0, 0, 0, 0,
                               1'b1, pins_of(3'b111, 3'b101, 1'b0, 1'b0, 1'b1, 3'd0)));
        script.push_back(entry(lmsd_pkg::KIND_DRAW,   1,  0, 0, 0, 1));
        script.push_back(entry(lmsd_pkg::KIND_TICK,   0,  0, 0, 0, 0));
        script.push_back(entry(lmsd_pkg::KIND_TICK,   0,  0, 0, 0, 0));
        script.push_back(entry(lmsd_pkg::KIND_CLEAR, 17, 33, 1, 0, 1));
        script.push_back(entry(lmsd_pkg::KIND_TICK,   0,  0, 0, 0, 0));
        script.push_back(entry(lmsd_pkg::KIND_TICK,   0,  0, 0, 0, 0));
        script.push_back(entry(lmsd_pkg::KIND_DRAW,  31,  7, 1, 1, 0));
        script.push_back(entry(lmsd_pkg::KIND_DRAW,  31,  0, 1, 0, 0));
        script.push_back(entry(KIND_IGNORED,          0,  0, 0, 0, 0));
        script.push_back(entry(lmsd_pkg::KIND_TICK,   0,  0, 0, 0, 0));
        script.push_back(entry(lmsd_pkg::KIND_TICK,   0,  0, 0, 0, 0));
        script.push_back(entry(lmsd_pkg::KIND_DRAW,   0,  0, 0, 0, 0));
        script.push_back(entry(lmsd_pkg::KIND_TICK,   0,  0, 0, 0, 0));

        // Hold reset, then release it away from the rising edge
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        foreach (script[i])
            offer(script[i].item, script[i].typed, script[i].want);

        // Random phases: retune the registers while idle, then stream items.
        // The phase boundaries fall wherever the scan stands, so new settings meet a running scan.
        foreach (plan[p])
        begin
            settle();
            reg_write_check(lmsd_pkg::REG_PANELS_WIDE,
                            lmsd_pkg::APB_DATA_W'(plan[p].wide), 32'h7);
            reg_write_check(lmsd_pkg::REG_PANELS_HIGH,
                            lmsd_pkg::APB_DATA_W'(plan[p].high), 32'h7);
            reg_write_check(lmsd_pkg::REG_ON_TIME,
                            lmsd_pkg::APB_DATA_W'(plan[p].on_time), 32'hFFFF);
            if (plan[p].hold)
                hold_pending = 1'b1;
            done   = 0;
            paused = 1'b0;
            while (done < plan[p].count)
            begin
                // Halfway through, stop sending until every snapshot is back
                if (plan[p].drain && !paused && done >= plan[p].count / 2)
                begin
                    settle();
                    paused = 1'b1;
                end
                // Flip between idling and full-rate stretches now and then
                if ($urandom_range(0, 39) == 0)
                    calm = !calm;
                it = random_item(in_use);
                offer(it, 1'b0, '0);
                if (in_use)
                    done++;
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (fault_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/lmsd_pkg.sv
hdl/lmsd_in_if.sv
hdl/lmsd_out_if.sv
hdl/lmsd_pixel_ram.sv
hdl/lmsd_cfg.sv
hdl/lmsd_scan.sv
hdl/led_matrix_scan_driver.sv
test/led_matrix_scan_driver_test.sv
